[rtl/spi_framed_request_engine_unit_defines.svh]
// assertion macros for the framed request engine
`ifndef SPI_FRAMED_REQUEST_ENGINE_UNIT_DEFINES_SVH
`define SPI_FRAMED_REQUEST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SFRE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SFRE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sfre_pkg.sv]
// shared types and constants of the framed request engine
`default_nettype none
package sfre_pkg;

  localparam int ADDR_W = 3;

  localparam logic [7:0] HDR_BYTE      = 8'hAA;
  localparam logic [7:0] SYNC_BYTE     = 8'hAB;
  localparam logic [1:0] SYNC_NEEDED   = 2'd3;
  localparam logic [7:0] TIMEOUT_RESET = 8'd30;

  localparam logic [ADDR_W-1:0] REG_TIMEOUT_POLLS = 3'd0;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PAYLOAD = 2'd1;
  localparam logic [1:0] CMD_REPLY   = 2'd2;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_HUNT,
    PH_STATUS,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_PAYLOAD,
    JOB_SINGLE
  } job_kind_t;

  // one queued unit of output work, expanded into beats by the back end
  typedef struct packed {
    job_kind_t  jk;
    logic [1:0] res_kind;
    logic       with_sum;
    logic       done;
    logic [2:0] ct;
    logic [7:0] addr;
    logic [7:0] cnt;
    logic [7:0] dat;
    logic [7:0] sum;
  } job_t;

endpackage
`default_nettype wire

[rtl/sfre_front.sv]
// front end: takes items, runs the protocol state and emits output jobs
`default_nettype none
module sfre_front import sfre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [1:0] cmd,
  input  wire logic [2:0] call_type,
  input  wire logic [7:0] reg_addr,
  input  wire logic [7:0] byte_count,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] timeout_polls,
  output job_t            push_job,
  output logic            push
);

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] saved_count, saved_count_next;
  logic [7:0] bytes_done, bytes_done_next;
  logic [1:0] sync_run, sync_run_next;
  logic [7:0] poll_count, poll_count_next;

  logic [7:0] start_sum;
  logic [7:0] pay_sum;
  logic [7:0] bd_inc;
  logic [7:0] pc_inc;
  logic [1:0] sr_inc;

  assign start_sum = {5'b0, call_type} + reg_addr + byte_count;
  assign pay_sum   = running_sum + data_byte;
  assign bd_inc    = bytes_done + 8'd1;
  assign pc_inc    = poll_count + 8'd1;
  assign sr_inc    = (data_byte == SYNC_BYTE) ? (sync_run + 2'd1) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_sum <= '0;
      saved_count <= '0;
      bytes_done  <= '0;
      sync_run    <= '0;
      poll_count  <= '0;
    end else begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      saved_count <= saved_count_next;
      bytes_done  <= bytes_done_next;
      sync_run    <= sync_run_next;
      poll_count  <= poll_count_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    saved_count_next = saved_count;
    bytes_done_next  = bytes_done;
    sync_run_next    = sync_run;
    poll_count_next  = poll_count;
    push             = 1'b0;
    push_job         = '0;
    push_job.jk       = JOB_SINGLE;
    push_job.res_kind = KIND_TX;
    push_job.ct       = call_type;
    push_job.addr     = reg_addr;
    push_job.cnt      = byte_count;
    push_job.dat      = data_byte;
    if (accept) begin
      case (cmd)
        CMD_START: begin
          push              = 1'b1;
          push_job.jk       = JOB_START;
          push_job.sum      = start_sum;
          push_job.with_sum = (byte_count == 8'd0);
          running_sum_next  = start_sum;
          saved_count_next  = byte_count;
          bytes_done_next   = '0;
          if (byte_count == 8'd0) begin
            phase_next      = PH_HUNT;
            sync_run_next   = '0;
            poll_count_next = '0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        CMD_PAYLOAD: begin
          if (phase == PH_PAYLOAD) begin
            push              = 1'b1;
            push_job.jk       = JOB_PAYLOAD;
            push_job.sum      = pay_sum;
            push_job.with_sum = (bd_inc == saved_count);
            running_sum_next  = pay_sum;
            bytes_done_next   = bd_inc;
            if (bd_inc == saved_count) begin
              phase_next      = PH_HUNT;
              sync_run_next   = '0;
              poll_count_next = '0;
            end
          end
        end
        CMD_REPLY: begin
          case (phase)
            PH_HUNT: begin
              // sync beats a timeout on the same poll
              if (sr_inc == SYNC_NEEDED) begin
                phase_next      = PH_STATUS;
                sync_run_next   = '0;
                poll_count_next = '0;
              end else if (pc_inc == timeout_polls) begin
                push              = 1'b1;
                push_job.res_kind = KIND_TIMEOUT;
                push_job.dat      = '0;
                push_job.done     = 1'b1;
                phase_next        = PH_IDLE;
                sync_run_next     = '0;
                poll_count_next   = '0;
              end else begin
                sync_run_next   = sr_inc;
                poll_count_next = pc_inc;
              end
            end
            PH_STATUS: begin
              push              = 1'b1;
              push_job.res_kind = KIND_STATUS;
              if (saved_count == 8'd0) begin
                push_job.done = 1'b1;
                phase_next    = PH_IDLE;
              end else begin
                bytes_done_next = '0;
                phase_next      = PH_DATA;
              end
            end
            PH_DATA: begin
              push              = 1'b1;
              push_job.res_kind = KIND_DATA;
              bytes_done_next   = bd_inc;
              if (bd_inc == saved_count) begin
                push_job.done = 1'b1;
                phase_next    = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/sfre_queue.sv]
// job queue between front and back end
`default_nettype none
module sfre_queue import sfre_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/sfre_back.sv]
// back end: walks the head job one output beat per cycle while out_stall is low
`default_nettype none
module sfre_back import sfre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire job_t       head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      value,
  output logic            last,
  output logic            transaction_done
);

  logic [2:0] beat, beat_next;
  logic [2:0] last_beat;

  always_comb begin
    case (head_job.jk)
      JOB_START:   last_beat = head_job.with_sum ? 3'd6 : 3'd5;
      JOB_PAYLOAD: last_beat = head_job.with_sum ? 3'd1 : 3'd0;
      default:     last_beat = 3'd0;
    endcase
  end

  assign out_valid        = head_valid;
  assign kind             = head_job.res_kind;
  assign last             = (beat == last_beat);
  assign transaction_done = head_job.done;
  assign pop              = head_valid && !out_stall && last;

  always_comb begin
    case (head_job.jk)
      JOB_START: begin
        case (beat)
          3'd0, 3'd1, 3'd2: value = HDR_BYTE;
          3'd3:             value = {5'b0, head_job.ct};
          3'd4:             value = head_job.addr;
          3'd5:             value = head_job.cnt;
          default:          value = head_job.sum;
        endcase
      end
      JOB_PAYLOAD: value = (beat == 3'd0) ? head_job.dat : head_job.sum;
      default:     value = head_job.dat;
    endcase
  end

  always_comb begin
    beat_next = beat;
    if (head_valid && !out_stall) begin
      beat_next = last ? 3'd0 : beat + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else begin
      beat <= beat_next;
    end
  end

endmodule
`default_nettype wire

[rtl/spi_framed_request_engine_unit.sv]
// top level of the framed spi request engine
// the result beats of an item are registered in the job queue before they are shown
// throughput: one item per cycle while the job queue has room; output runs one beat per
// cycle while out_stall is low, a start item giving six or seven beats, set by the back end beat walker
// reset: synchronous, clears the protocol phase and counters, empties the job queue
// and sets timeout_polls to 30
`default_nettype none
`include "spi_framed_request_engine_unit_defines.svh"
module spi_framed_request_engine_unit import sfre_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [2:0]        call_type,
  input  wire logic [7:0]        reg_addr,
  input  wire logic [7:0]        byte_count,
  input  wire logic [7:0]        data_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             value,
  output logic                   last,
  output logic                   transaction_done
);

  logic [7:0] timeout_polls;
  logic       cfg_wr;
  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;
  job_t       push_job;
  job_t       head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_TIMEOUT_POLLS) ? {24'b0, timeout_polls} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_polls <= TIMEOUT_RESET;
    end else if (cfg_wr && paddr == REG_TIMEOUT_POLLS) begin
      timeout_polls <= pwdata[7:0];
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  sfre_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .call_type     (call_type),
    .reg_addr      (reg_addr),
    .byte_count    (byte_count),
    .data_byte     (data_byte),
    .timeout_polls (timeout_polls),
    .push_job      (push_job),
    .push          (push)
  );

  sfre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfre_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .value            (value),
    .last             (last),
    .transaction_done (transaction_done)
  );

  `SFRE_ASSERT_IMP(a_done_is_last, out_valid && transaction_done, last, "done beat is not last")
  `SFRE_ASSERT_IMP(a_timeout_beat, out_valid && kind == KIND_TIMEOUT, value == 8'd0 && last && transaction_done, "bad timeout beat")
  `SFRE_ASSERT_NXT(a_cfg_write, cfg_wr && paddr == REG_TIMEOUT_POLLS, timeout_polls == $past(pwdata[7:0]), "timeout_polls not written")

endmodule
`default_nettype wire
